// ===== rtl/core/dsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the digitizer sample calibration core: sizes, codes and state types.
// Used by every module of the core; depends on nothing.
package dsc_pkg;

  // Store dimensions.
  localparam int BINS            = 128;
  localparam int CHANNELS        = 4;
  localparam int CHIPS           = 2;
  localparam int BASELINE_POINTS = 16;

  localparam int NCC      = CHIPS * CHANNELS;
  localparam int CC_W     = $clog2(NCC);
  localparam int FIT_DEPTH = NCC * BINS;
  localparam int FIT_AW   = $clog2(FIT_DEPTH);
  localparam int BL_DEPTH = NCC * BASELINE_POINTS;
  localparam int BL_AW    = $clog2(BL_DEPTH);
  localparam int PT_CNT_W = $clog2(BASELINE_POINTS + 1);

  // Divider operand widths.
  localparam int DIV_NUM_W = 66;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  typedef enum logic [2:0] {
    ACT_LOAD_FIT  = 3'd0,
    ACT_LOAD_BL   = 3'd1,
    ACT_LOAD_GAIN = 3'd2,
    ACT_TO_VOLTS  = 3'd3,
    ACT_TO_COUNT  = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFIT  = 3'd1,
    ST_RANGE  = 3'd2,
    ST_NOGAIN = 3'd3,
    ST_ZERO   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOAD,
    S_FIT_RD,
    S_FIT_CHK,
    S_BL_RD,
    S_BL_CHK,
    S_BL_END,
    S_BL_MUL,
    S_BL_DIV,
    S_BL_WAIT,
    S_CHK2,
    S_MUL,
    S_NUM,
    S_WAIT,
    S_OUT
  } state_t;

endpackage

// ===== rtl/core/dsc_div.sv =====
`timescale 1ns / 1ps
// Serial signed divider: rounds to nearest with ties away from zero and saturates to 32 bits.
// Depends on dsc_pkg for operand widths.
module dsc_div import dsc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [DIV_NUM_W-1:0] num,
  input  logic signed [DIV_DEN_W-1:0] den,
  output logic                        done,
  output logic signed [31:0]          quo
);

  logic                  busy;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [DIV_DEN_W:0]    rem;
  logic [DIV_NUM_W-1:0]  dq;
  logic [DIV_DEN_W-1:0]  ud;
  logic                  neg;

  logic [DIV_NUM_W-1:0]  un;
  logic [DIV_DEN_W-1:0]  ud_in;
  logic [DIV_DEN_W:0]    sh;
  logic                  qbit;

  // Operand magnitudes.
  assign un    = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
  assign ud_in = den[DIV_DEN_W-1] ? DIV_DEN_W'(-den) : DIV_DEN_W'(den);

  // One restoring step.
  assign sh   = {rem[DIV_DEN_W-1:0], dq[DIV_NUM_W-1]};
  assign qbit = (sh >= {1'b0, ud});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the dividend carries half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
      ud  <= ud_in;
      dq  <= un + DIV_NUM_W'(ud_in >> 1);
      rem <= '0;
    end else if (busy) begin
      rem <= qbit ? (sh - {1'b0, ud}) : sh;
      dq  <= {dq[DIV_NUM_W-2:0], qbit};
    end
  end

  // Saturate the quotient to the signed 32-bit range.
  always_comb begin
    if (neg) begin
      if (dq > DIV_NUM_W'(33'h080000000)) quo = 32'sh80000000;
      else quo = -$signed(dq[31:0]);
    end else begin
      if (dq > DIV_NUM_W'(32'h7fffffff)) quo = 32'sh7fffffff;
      else quo = $signed(dq[31:0]);
    end
  end

endmodule

// ===== rtl/core/dsc_fit_store.sv =====
`timescale 1ns / 1ps
// Fit store: per-bin slope and intercept with a valid bit, in one synchronous memory.
// Depends on dsc_pkg; a clearing pass over all entries runs after reset.
module dsc_fit_store import dsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [FIT_AW-1:0] wr_addr,
  input  logic [63:0]       wr_data,
  input  logic              rd_en,
  input  logic [FIT_AW-1:0] rd_addr,
  output logic              rd_valid,
  output logic [63:0]       rd_data,
  output logic              busy
);

  logic [64:0]       mem [FIT_DEPTH];
  logic [FIT_AW-1:0] clr_addr;
  logic [64:0]       rd_word;

  // Clearing sweep, one entry a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == FIT_AW'(FIT_DEPTH - 1)) busy <= 1'b0;
    end
  end

  // Single write port shared by the sweep and fit loads.
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr_en) begin
      mem[wr_addr] <= {1'b1, wr_data};
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd_en) rd_word <= mem[rd_addr];
  end

  assign rd_valid = rd_word[64];
  assign rd_data  = rd_word[63:0];

endmodule

// ===== rtl/core/digitizer_sample_calibration_core.sv =====
`timescale 1ns / 1ps
// Top level of the digitizer sample calibration core: sequencer, baseline memory, gains.
// Depends on dsc_pkg, dsc_fit_store and dsc_div.
//
//  Channel  Dir  tdata                                   tuser
//  s_*      in   136 bits: chip_id, channel, bin_index,  action (3)
//                point_index, sample_count, high_voltage,
//                pedestal, value_a, value_b
//  m_*      out  32 bits: result_value                   status (3)
//
// A load passes through S_LOAD to S_OUT; an unused action goes straight to S_OUT. A conversion
// reads the fit, walks the baseline points and runs two divisions in the serial divider:
// one for the baseline, one for the result.
// After reset the fit memory is swept clear; s_tready stays low until the sweep ends.
// One word is in work at a time; a finished word waits in the output register.
module digitizer_sample_calibration_core import dsc_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // chip_id[0], channel[2:1], bin_index[9:3], point_index[13:10], sample_count[23:14],
  // high_voltage[35:24], pedestal[67:36], value_a[99:68], value_b[131:100], zero fill
  input  logic [135:0] s_tdata,
  // action[2:0]
  input  logic [2:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_value[31:0]
  output logic [31:0]  m_tdata,
  // status[2:0]
  output logic [2:0]   m_tuser
);

  state_t state, state_next;

  // Captured word.
  action_t            act;
  logic               chip;
  logic [1:0]         ch;
  logic [6:0]         bin;
  logic [3:0]         pt;
  logic [9:0]         cnt;
  logic [11:0]        hv;
  logic signed [31:0] ped, va_in, vb_in;

  // Work registers.
  logic signed [31:0] slope, icpt, g;
  logic               gok;
  logic [PT_CNT_W-1:0] idx, n;
  logic               lo, hi;
  logic [11:0]        pv_b, pv_a;
  logic signed [31:0] pb_b, pb_a;
  logic signed [32:0] base;
  logic signed [65:0] prod;
  status_t            status;
  logic signed [31:0] res;

  // Stores held in registers and memory.
  logic [PT_CNT_W-1:0] bl_count [NCC];
  logic [31:0]         gain_tab [CHANNELS];
  logic                gain_vld [CHANNELS];
  logic [43:0]         bl_mem [BL_DEPTH];
  logic [43:0]         bl_rd;

  logic               cc_ok;
  logic [CC_W-1:0]    cc;
  logic               to_volts;
  logic               accept;

  logic              fit_wr, fit_rd, fit_valid, fit_busy;
  logic [FIT_AW-1:0] fit_wa, fit_ra;
  logic [63:0]       fit_data;

  logic               div_start, div_done;
  logic signed [DIV_NUM_W-1:0] div_num;
  logic signed [DIV_DEN_W-1:0] div_den;
  logic signed [31:0] div_quo;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] t_c2v, t_v2c;
  logic [11:0]        pv;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == S_IDLE) && !fit_busy;
  assign cc_ok    = (int'(chip) < CHIPS) && (int'(ch) < CHANNELS);
  assign cc       = CC_W'(int'(chip) * CHANNELS + int'(ch));
  assign to_volts = (act == ACT_TO_VOLTS);
  assign pv       = bl_rd[43:32];

  dsc_fit_store u_fit (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fit_wr),
    .wr_addr  (fit_wa),
    .wr_data  ({va_in, vb_in}),
    .rd_en    (fit_rd),
    .rd_addr  (fit_ra),
    .rd_valid (fit_valid),
    .rd_data  (fit_data),
    .busy     (fit_busy)
  );

  dsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Fit store addresses: loads go to the mirrored bin.
  assign fit_wa = FIT_AW'(int'(cc) * BINS + BINS - 1 - int'(bin));
  assign fit_ra = FIT_AW'(int'(cc) * BINS + int'(bin));
  assign fit_wr = (state == S_LOAD) && (act == ACT_LOAD_FIT) && cc_ok && (int'(bin) < BINS);

  // Shared multiplier operands.
  always_comb begin
    if (state == S_BL_MUL) begin
      mul_a = 33'(pb_a) - 33'(pb_b);
      mul_b = $signed({21'd0, hv - pv_b});
    end else if (to_volts) begin
      mul_a = 33'(slope);
      mul_b = $signed({23'd0, cnt});
    end else begin
      mul_a = 33'(g);
      mul_b = 33'(va_in);
    end
  end

  // Divider operands.
  assign t_c2v = (prod + 66'(icpt) - 66'(ped) - 66'(base)) <<< 16;
  assign t_v2c = prod + ((66'(ped) + 66'(base) - 66'(icpt)) <<< 16);

  always_comb begin
    if (state == S_BL_DIV) begin
      div_num = prod;
      div_den = $signed({21'd0, pv_a - pv_b});
    end else if (to_volts) begin
      div_num = t_c2v;
      div_den = 33'(g);
    end else begin
      div_num = t_v2c;
      div_den = 33'(slope);
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Next state and strobes.
  always_comb begin
    state_next = state;
    fit_rd     = 1'b0;
    div_start  = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(s_tuser))
            ACT_LOAD_FIT, ACT_LOAD_BL, ACT_LOAD_GAIN: state_next = S_LOAD;
            ACT_TO_VOLTS, ACT_TO_COUNT: state_next = S_FIT_RD;
            default: state_next = S_OUT;
          endcase
        end
      end
      S_LOAD: state_next = S_OUT;
      S_FIT_RD: begin
        if (cc_ok && (int'(bin) < BINS)) begin
          fit_rd     = 1'b1;
          state_next = S_FIT_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FIT_CHK: begin
        if (!fit_valid) state_next = S_OUT;
        else if (!to_volts && !gain_vld[ch]) state_next = S_OUT;
        else state_next = S_BL_RD;
      end
      S_BL_RD: state_next = (idx < n) ? S_BL_CHK : S_BL_END;
      S_BL_CHK: begin
        if (hv < pv) state_next = S_BL_END;
        else state_next = S_BL_RD;
      end
      S_BL_END: state_next = (lo && hi) ? S_BL_MUL : S_OUT;
      S_BL_MUL: state_next = S_BL_DIV;
      S_BL_DIV: begin
        div_start  = 1'b1;
        state_next = S_BL_WAIT;
      end
      S_BL_WAIT: if (div_done) state_next = S_CHK2;
      S_CHK2: begin
        if (to_volts) state_next = (!gok || g == 32'sd0) ? S_OUT : S_MUL;
        else state_next = (slope == 32'sd0) ? S_OUT : S_MUL;
      end
      S_MUL: state_next = S_NUM;
      S_NUM: begin
        div_start  = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: if (div_done) state_next = S_OUT;
      S_OUT: if (!m_tvalid || m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Working datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          act    <= action_t'(s_tuser);
          chip   <= s_tdata[0];
          ch     <= s_tdata[2:1];
          bin    <= s_tdata[9:3];
          pt     <= s_tdata[13:10];
          cnt    <= s_tdata[23:14];
          hv     <= s_tdata[35:24];
          ped    <= $signed(s_tdata[67:36]);
          va_in  <= $signed(s_tdata[99:68]);
          vb_in  <= $signed(s_tdata[131:100]);
          status <= ST_OK;
          res    <= '0;
        end
      end
      S_FIT_RD: if (!(cc_ok && (int'(bin) < BINS))) status <= ST_NOFIT;
      S_FIT_CHK: begin
        slope <= $signed(fit_data[63:32]);
        icpt  <= $signed(fit_data[31:0]);
        gok   <= gain_vld[ch];
        g     <= gain_vld[ch] ? $signed(gain_tab[ch]) : 32'sd0;
        idx   <= '0;
        n     <= bl_count[cc];
        lo    <= 1'b0;
        hi    <= 1'b0;
        if (!fit_valid) status <= ST_NOFIT;
        else if (!to_volts && !gain_vld[ch]) status <= ST_NOGAIN;
      end
      S_BL_CHK: begin
        if (hv > pv) begin
          lo   <= 1'b1;
          pv_b <= pv;
          pb_b <= $signed(bl_rd[31:0]);
        end
        if (hv < pv) begin
          hi   <= 1'b1;
          pv_a <= pv;
          pb_a <= $signed(bl_rd[31:0]);
        end
        idx <= idx + 1'b1;
      end
      S_BL_END: if (!(lo && hi)) status <= ST_RANGE;
      S_BL_MUL, S_MUL: prod <= mul_a * mul_b;
      S_BL_WAIT: if (div_done) base <= 33'(div_quo) + 33'(pb_b);
      S_CHK2: begin
        if (to_volts) begin
          if (!gok) status <= ST_NOGAIN;
          else if (g == 32'sd0) status <= ST_ZERO;
        end else if (slope == 32'sd0) begin
          status <= ST_ZERO;
        end
      end
      S_WAIT: if (div_done) res <= div_quo;
      default: ;
    endcase
  end

  // Baseline memory: written on loads, read one point per S_BL_RD state during the walk.
  always_ff @(posedge clk) begin
    if (state == S_LOAD && act == ACT_LOAD_BL && cc_ok && (int'(pt) < BASELINE_POINTS)) begin
      bl_mem[BL_AW'(int'(cc) * BASELINE_POINTS + int'(pt))] <= {hv, va_in};
    end
    if (state == S_BL_RD) begin
      bl_rd <= bl_mem[BL_AW'(int'(cc) * BASELINE_POINTS + int'(idx))];
    end
  end

  // Point counts and gains.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NCC; i++) bl_count[i] <= '0;
      for (int i = 0; i < CHANNELS; i++) gain_vld[i] <= 1'b0;
    end else if (state == S_LOAD) begin
      if (act == ACT_LOAD_BL && cc_ok && (int'(pt) < BASELINE_POINTS)) begin
        if (int'(bl_count[cc]) < int'(pt) + 1) bl_count[cc] <= PT_CNT_W'(int'(pt) + 1);
      end
      if (act == ACT_LOAD_GAIN && (int'(ch) < CHANNELS) && !gain_vld[ch]) begin
        gain_vld[ch] <= 1'b1;
        gain_tab[ch] <= va_in;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      m_tuser <= status;
      m_tdata <= (status == ST_OK) ? res : 32'd0;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the digitizer sample calibration core: directed and random
// load and conversion words, an in-bench predictor, and result checking. Depends on dsc_pkg.
module tb_top;
  import dsc_pkg::*;

  // Packed so that the low 132 bits match the tdata layout, chip_id in bit 0.
  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] value_b;
    logic [31:0] value_a;
    logic [31:0] pedestal;
    logic [11:0] high_voltage;
    logic [9:0]  sample_count;
    logic [3:0]  point_index;
    logic [6:0]  bin_index;
    logic [1:0]  channel;
    logic        chip_id;
  } cal_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] value;
  } cal_result_t;

  localparam int STALL_LIMIT = 20000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [135:0] s_tdata;
  logic [2:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [31:0]  m_tdata;
  logic [2:0]   m_tuser;

  digitizer_sample_calibration_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Predictor state, mirroring the core's stores.
  logic [63:0] fit_mem [FIT_DEPTH];
  logic        fit_ok [FIT_DEPTH];
  logic [43:0] bl_mem [BL_DEPTH];
  logic [4:0]  bl_cnt [NCC];
  logic [31:0] gain_mem [CHANNELS];
  logic        gain_ok [CHANNELS];

  cal_word_t   pending_words[$];
  cal_result_t expected_results[$];
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        hold_send;
  int          errors;
  int          stall_cycles;

  // Rounded division, ties away from zero, saturated to 32 bits.
  function automatic logic signed [31:0] round_div(input logic signed [127:0] n,
                                                   input logic signed [127:0] d);
    logic         neg;
    logic [127:0] un;
    logic [127:0] ud;
    logic [127:0] q;
    neg = (n < 0) != (d < 0);
    un = n < 0 ? -n : n;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    if (neg) return q > 128'h8000_0000 ? 32'sh8000_0000 : -q[31:0];
    return q > 128'h7FFF_FFFF ? 32'sh7FFF_FFFF : q[31:0];
  endfunction

  // Interpolates the baseline at hv; returns 0 when hv is not bracketed.
  function automatic logic interp_baseline(input int cc, input int hv,
                                           output logic signed [127:0] base);
    logic lo;
    logic hi;
    int   vlo;
    int   vhi;
    int   v;
    logic signed [127:0] blo;
    logic signed [127:0] bhi;
    lo = 0; hi = 0; vlo = 0; vhi = 0; blo = 0; bhi = 0; base = 0;
    for (int i = 0; i < bl_cnt[cc] && i < BASELINE_POINTS; i++) begin
      v = bl_mem[cc*BASELINE_POINTS+i][43:32];
      if (hv > v) begin
        vlo = v; blo = $signed(bl_mem[cc*BASELINE_POINTS+i][31:0]); lo = 1;
      end
      if (hv < v) begin
        vhi = v; bhi = $signed(bl_mem[cc*BASELINE_POINTS+i][31:0]); hi = 1;
        break;
      end
    end
    if (!lo || !hi) return 0;
    base = round_div((hv - vlo) * (bhi - blo), vhi - vlo) + blo;
    return 1;
  endfunction

  function automatic cal_result_t calibrate(input cal_word_t w);
    cal_result_t r;
    int          cc;
    int          idx;
    logic signed [127:0] slope;
    logic signed [127:0] icpt;
    logic signed [127:0] base;
    logic signed [127:0] g;
    logic        have_base;
    r.status = ST_OK;
    r.value = '0;
    cc = w.chip_id * CHANNELS + w.channel;
    case (w.action)
      ACT_LOAD_FIT: begin
        idx = cc * BINS + (BINS - 1 - w.bin_index);
        fit_mem[idx] = {w.value_a, w.value_b};
        fit_ok[idx] = 1;
      end
      ACT_LOAD_BL: begin
        bl_mem[cc*BASELINE_POINTS+w.point_index] = {w.high_voltage, w.value_a};
        if (bl_cnt[cc] < w.point_index + 1) bl_cnt[cc] = 5'(w.point_index + 1);
      end
      ACT_LOAD_GAIN: begin
        if (!gain_ok[w.channel]) begin
          gain_mem[w.channel] = w.value_a;
          gain_ok[w.channel] = 1;
        end
      end
      ACT_TO_VOLTS, ACT_TO_COUNT: begin
        idx = cc * BINS + w.bin_index;
        if (!fit_ok[idx]) begin
          r.status = ST_NOFIT;
        end else begin
          slope = $signed(fit_mem[idx][63:32]);
          icpt = $signed(fit_mem[idx][31:0]);
          g = gain_ok[w.channel] ? $signed(gain_mem[w.channel]) : 0;
          have_base = interp_baseline(cc, w.high_voltage, base);
          if (w.action == ACT_TO_VOLTS) begin
            if (!have_base) r.status = ST_RANGE;
            else if (!gain_ok[w.channel]) r.status = ST_NOGAIN;
            else if (g == 0) r.status = ST_ZERO;
            else r.value = round_div((slope * $signed({1'b0, w.sample_count}) + icpt
                - $signed(w.pedestal) - base) * 65536, g);
          end else begin
            if (!gain_ok[w.channel]) r.status = ST_NOGAIN;
            else if (!have_base) r.status = ST_RANGE;
            else if (slope == 0) r.status = ST_ZERO;
            else r.value = round_div(g * $signed(w.value_a)
                + ($signed(w.pedestal) + base - icpt) * 65536, slope);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Clock generation.
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Driver: presents queued words and applies the predictor on each accepted word.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(calibrate(cal_word_t'({s_tuser, s_tdata[131:0]})));
        void'(pending_words.pop_front());
      end
      if (pending_words.size() > (s_tvalid && s_tready ? 0 : 0) && !hold_send
          && ($urandom_range(99) >= send_idle_pct || (s_tvalid && !s_tready))) begin
        s_tvalid <= 1;
        s_tuser <= pending_words[0].action;
        s_tdata <= {4'b0, pending_words[0][131:0]};
      end else if (!(s_tvalid && !s_tready)) begin
        s_tvalid <= 0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    cal_result_t exp_r;
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= $urandom_range(99) >= recv_idle_pct;
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected word status=%0d value=%h", $time, m_tuser, m_tdata);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tuser !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, m_tuser);
            errors++;
          end
          if (m_tdata !== exp_r.value) begin
            $display("%0t: value expected %h actual %h", $time, exp_r.value, m_tdata);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("digitizer_sample_calibration_core test failed");
        $finish;
      end
    end
  end

  function automatic cal_word_t rand_word(input logic [2:0] act);
    cal_word_t w;
    w = cal_word_t'(135'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    w.action = act;
    w.chip_id = 1'($urandom_range(1));
    w.channel = 2'($urandom_range(3));
    // Keep most values modest so results stay in range, with some full-scale ones.
    if ($urandom_range(3) != 0) begin
      w.value_a = $signed($urandom_range(32'h0003_0000)) - 32'sh0001_8000;
      w.value_b = $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      w.pedestal = $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
    end
    return w;
  endfunction

  // Queues a baseline curve of n ascending points for one chip and channel.
  task automatic queue_curve(input logic chip, input logic [1:0] ch, input int n);
    cal_word_t w;
    int        hv;
    hv = $urandom_range(200);
    for (int i = 0; i < n; i++) begin
      w = rand_word(ACT_LOAD_BL);
      w.chip_id = chip; w.channel = ch; w.point_index = 4'(i);
      w.high_voltage = 12'(hv);
      pending_words.push_back(w);
      hv = hv + 1 + $urandom_range(4095 / n - 1);
      if (hv > 4095) hv = 4095;
    end
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    cal_word_t w;
    logic [2:0] act;
    logic       pressed;
    rst = 1;
    s_tvalid = 0; s_tdata = '0; s_tuser = '0; m_tready = 0;
    hold_send = 0; errors = 0; stall_cycles = 0; pressed = 0;
    send_idle_pct = 34; recv_idle_pct = 53;
    for (int i = 0; i < FIT_DEPTH; i++) begin fit_mem[i] = '0; fit_ok[i] = 0; end
    for (int i = 0; i < BL_DEPTH; i++) bl_mem[i] = '0;
    for (int i = 0; i < NCC; i++) bl_cnt[i] = '0;
    for (int i = 0; i < CHANNELS; i++) begin gain_mem[i] = '0; gain_ok[i] = 0; end
    repeat (12) @(posedge clk);
    rst <= 0;

    // Directed: conversions with nothing loaded, an unused action, loads at the extremes, zero divisors.
    w = rand_word(ACT_TO_VOLTS); pending_words.push_back(w);
    w = rand_word(ACT_TO_COUNT); pending_words.push_back(w);
    w = rand_word(3'd7); pending_words.push_back(w);
    w = rand_word(ACT_LOAD_FIT); w.chip_id = 1; w.channel = 3; w.bin_index = 0;
    w.value_a = 32'sh7FFF_FFFF; w.value_b = 32'sh8000_0000; pending_words.push_back(w);
    w = rand_word(ACT_LOAD_FIT); w.chip_id = 1; w.channel = 3; w.bin_index = 127;
    w.value_a = 0; w.value_b = 32'sh0001_0000; pending_words.push_back(w);
    w = rand_word(ACT_TO_VOLTS); w.chip_id = 1; w.channel = 3; w.bin_index = 0;
    pending_words.push_back(w);
    queue_curve(1, 3, 16);
    w = rand_word(ACT_LOAD_BL); w.chip_id = 0; w.channel = 0; w.point_index = 0;
    w.high_voltage = 4095; pending_words.push_back(w);
    w = rand_word(ACT_TO_COUNT); w.chip_id = 1; w.channel = 3; w.bin_index = 0;
    w.high_voltage = 300; pending_words.push_back(w);
    w = rand_word(ACT_LOAD_GAIN); w.channel = 3; w.value_a = 0; pending_words.push_back(w);
    w = rand_word(ACT_LOAD_GAIN); w.channel = 3; w.value_a = 32'sh0001_0000;
    pending_words.push_back(w);
    w = rand_word(ACT_TO_VOLTS); w.chip_id = 1; w.channel = 3; w.bin_index = 127;
    w.high_voltage = 0; pending_words.push_back(w);
    w = rand_word(ACT_TO_VOLTS); w.chip_id = 1; w.channel = 3; w.bin_index = 127;
    w.high_voltage = 1000; w.sample_count = 1023; pending_words.push_back(w);
    w = rand_word(ACT_TO_COUNT); w.chip_id = 1; w.channel = 3; w.bin_index = 0;
    w.high_voltage = 1000; pending_words.push_back(w);

    // Random phases: sender and receiver idling swap, then no idling.
    for (int phase = 0; phase < 3; phase++) begin
      for (int n = 0; n < 530; n++) begin
        if ($urandom_range(99) < 5) begin
          queue_curve(1'($urandom_range(1)), 2'($urandom_range(3)), 2 + $urandom_range(14));
          n += 8;
        end else begin
          act = $urandom_range(99) < 15 ? 3'($urandom_range(2))
              : $urandom_range(99) < 3 ? 3'($urandom_range(7, 5))
              : 3'($urandom_range(4, 3));
          w = rand_word(act);
          // Conversions mostly aim at a bin that the mirrored fit load wrote.
          if (act == ACT_TO_VOLTS || act == ACT_TO_COUNT) begin
            w.bin_index = $urandom_range(7) == 0 ? 7'($urandom) : 7'(127 - $urandom_range(7));
          end else if (act == ACT_LOAD_FIT) begin
            w.bin_index = $urandom_range(3) == 0 ? 7'($urandom) : 7'($urandom_range(7));
          end
          pending_words.push_back(w);
        end
        // Pause the sender until every outstanding result has come back.
        if (phase == 0 && n >= 200 && !pressed) begin
          pressed = 1;
          hold_send = 1;
          while (s_tvalid || expected_results.size() != 0) @(posedge clk);
          hold_send = 0;
        end
      end
      wait_drained();
      if (phase == 0) begin send_idle_pct = 53; recv_idle_pct = 34; end
      else begin send_idle_pct = 0; recv_idle_pct = 0; end
    end

    repeat (300) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("digitizer_sample_calibration_core test passed");
    else
      $display("digitizer_sample_calibration_core test failed");
    $finish;
  end

endmodule
